// ----- hw/rtl/bfr_pkg.sv -----
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_EDGES_DEF    = 32;
    localparam int WEIGHT_BITS      = 16;

    localparam int DIST_W    = 21;
    localparam int VAL_W     = 22;
    localparam int VCNT_W    = 5;
    localparam int ECNT_W    = 6;
    localparam int VTX_W     = 4;
    localparam int SLOT_W    = 5;
    localparam int IDX_OUT_W = 5;
    localparam int PC_W      = 4;
    localparam int CMP_W     = 10;

    localparam logic [VCNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    // input word selector
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_RUN  = 1'b1;

    // register slots, paddr[3:2]
    localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] REG_EDGE_COUNT    = 2'd1;
    localparam logic [1:0] REG_SOURCE_VERTEX = 2'd2;

    typedef enum logic [1:0] {
        KIND_POTENTIAL,
        KIND_EDGE,
        KIND_STATUS
    } t_kind;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_RELAX,
        OP_NEXT_PASS,
        OP_CHECK,
        OP_CLR_J,
        OP_EMIT_VTX,
        OP_EMIT_EDGE,
        OP_EMIT_STAT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_PASS,
        C_NO_EDGE,
        C_MORE_EDGES,
        C_MORE_PASS,
        C_NO_VERTEX,
        C_MORE_VTX
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
        logic  vsel;
        logic  wait_out;
        logic  fin;
    } t_ctl;

    typedef struct packed {
        logic no_pass;
        logic no_edge;
        logic more_edges;
        logic more_pass;
        logic no_vertex;
        logic more_vtx;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic [VTX_W-1:0]       src;
        logic [VTX_W-1:0]       dest;
        logic [WEIGHT_BITS-1:0] weight;
    } t_edge;

endpackage

// ----- hw/rtl/bfr_seq.sv -----
`timescale 1ns / 1ps

module bfr_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bfr_pkg::t_flags i_flags,
    output bfr_pkg::t_ctl   o_ctl,
    output logic            o_exec,
    output logic            o_busy
);
    import bfr_pkg::*;

    localparam t_pc PC_INIT      = t_pc'(0);
    localparam t_pc PC_RELAX_A   = t_pc'(1);
    localparam t_pc PC_RELAX_B   = t_pc'(2);
    localparam t_pc PC_RELAX_C   = t_pc'(3);
    localparam t_pc PC_NEXT_PASS = t_pc'(4);
    localparam t_pc PC_CHECK_A   = t_pc'(5);
    localparam t_pc PC_CHECK_B   = t_pc'(6);
    localparam t_pc PC_CHECK_C   = t_pc'(7);
    localparam t_pc PC_VTX_INIT  = t_pc'(8);
    localparam t_pc PC_VTX_A     = t_pc'(9);
    localparam t_pc PC_VTX_B     = t_pc'(10);
    localparam t_pc PC_EDGE_INIT = t_pc'(11);
    localparam t_pc PC_EDGE_A    = t_pc'(12);
    localparam t_pc PC_EDGE_B    = t_pc'(13);
    localparam t_pc PC_EDGE_C    = t_pc'(14);
    localparam t_pc PC_STATUS    = t_pc'(15);

    logic r_busy, n_busy;
    t_pc  r_pc, n_pc;
    t_ctl cw;
    logic cond_hit;
    logic exec;

    function automatic t_ctl ucode_word(input t_op op, input t_cond cond, input t_pc tgt,
                                        input logic vsel, input logic wt, input logic fin);
        t_ctl c;
        c.op       = op;
        c.cond     = cond;
        c.target   = tgt;
        c.vsel     = vsel;
        c.wait_out = wt;
        c.fin      = fin;
        return c;
    endfunction

    // microcode store
    always_comb begin
        case (r_pc)
            PC_INIT:      cw = ucode_word(OP_INIT, C_NO_PASS, PC_CHECK_A, 1'b0, 1'b0, 1'b0);
            PC_RELAX_A:   cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b0);
            PC_RELAX_B:   cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b0);
            PC_RELAX_C:   cw = ucode_word(OP_RELAX, C_MORE_EDGES, PC_RELAX_A, 1'b0, 1'b0, 1'b0);
            PC_NEXT_PASS: cw = ucode_word(OP_NEXT_PASS, C_MORE_PASS, PC_RELAX_A,
                                          1'b0, 1'b0, 1'b0);
            PC_CHECK_A:   cw = ucode_word(OP_NOP, C_NO_EDGE, PC_VTX_INIT, 1'b0, 1'b0, 1'b0);
            PC_CHECK_B:   cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b0);
            PC_CHECK_C:   cw = ucode_word(OP_CHECK, C_MORE_EDGES, PC_CHECK_A, 1'b0, 1'b0, 1'b0);
            PC_VTX_INIT:  cw = ucode_word(OP_CLR_J, C_NO_VERTEX, PC_EDGE_INIT, 1'b0, 1'b0, 1'b0);
            PC_VTX_A:     cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b1, 1'b0, 1'b0);
            PC_VTX_B:     cw = ucode_word(OP_EMIT_VTX, C_MORE_VTX, PC_VTX_A, 1'b1, 1'b1, 1'b0);
            PC_EDGE_INIT: cw = ucode_word(OP_CLR_J, C_NO_EDGE, PC_STATUS, 1'b0, 1'b0, 1'b0);
            PC_EDGE_A:    cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b0);
            PC_EDGE_B:    cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b0);
            PC_EDGE_C:    cw = ucode_word(OP_EMIT_EDGE, C_MORE_EDGES, PC_EDGE_A,
                                          1'b0, 1'b1, 1'b0);
            PC_STATUS:    cw = ucode_word(OP_EMIT_STAT, C_NEVER, PC_INIT, 1'b0, 1'b1, 1'b1);
            default:      cw = ucode_word(OP_NOP, C_NEVER, PC_INIT, 1'b0, 1'b0, 1'b1);
        endcase
    end

    always_comb begin
        case (cw.cond)
            C_NO_PASS:    cond_hit = i_flags.no_pass;
            C_NO_EDGE:    cond_hit = i_flags.no_edge;
            C_MORE_EDGES: cond_hit = i_flags.more_edges;
            C_MORE_PASS:  cond_hit = i_flags.more_pass;
            C_NO_VERTEX:  cond_hit = i_flags.no_vertex;
            C_MORE_VTX:   cond_hit = i_flags.more_vtx;
            default:      cond_hit = 1'b0;
        endcase
    end

    // an emitting step holds until the output register is free
    assign exec = r_busy && (!cw.wait_out || i_flags.out_free);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = PC_INIT;
            end
        end else if (exec) begin
            if (cond_hit) begin
                n_pc = cw.target;
            end else if (cw.fin) begin
                n_busy = 1'b0;
                n_pc   = PC_INIT;
            end else begin
                n_pc = r_pc + t_pc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_INIT;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ctl  = cw;
    assign o_exec = exec;
    assign o_busy = r_busy;

    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pc == PC_INIT)
        else $error("sequencer idle away from the first step");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("run command did not start the sequencer");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && cw.fin && !cond_hit |=> !r_busy)
        else $error("sequencer ran past the final step");

endmodule

// ----- hw/rtl/bfr_dp.sv -----
`timescale 1ns / 1ps

module bfr_dp #(
    parameter int MAX_VERTICES = bfr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfr_pkg::MAX_EDGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic [bfr_pkg::SLOT_W-1:0]           i_load_index,
    input  bfr_pkg::t_edge                       i_load_edge,
    input  logic [bfr_pkg::VCNT_W-1:0]           i_vertex_count,
    input  logic [bfr_pkg::ECNT_W-1:0]           i_edge_count,
    input  logic [bfr_pkg::VTX_W-1:0]            i_source_vertex,
    input  bfr_pkg::t_ctl                        i_ctl,
    input  logic                                 i_exec,
    input  logic                                 i_out_ready,
    output bfr_pkg::t_flags                      o_flags,
    output logic                                 o_out_valid,
    output bfr_pkg::t_kind                       o_kind,
    output logic [bfr_pkg::IDX_OUT_W-1:0]        o_item_index,
    output logic signed [bfr_pkg::VAL_W-1:0]     o_value,
    output logic                                 o_reachable,
    output logic                                 o_negative_cycle,
    output logic                                 o_last
);
    import bfr_pkg::*;

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VCW    = $clog2(MAX_VERTICES + 1);
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int JW     = (VCW > ECW) ? VCW : ECW;
    localparam int JW1    = JW + 1;

    localparam logic signed [VAL_W-1:0] DIST_MAX = 22'sd1048575;
    localparam logic signed [VAL_W-1:0] DIST_MIN = -22'sd1048576;
    localparam logic signed [VAL_W:0]   VAL_MAX  = 23'sd2097151;
    localparam logic signed [VAL_W:0]   VAL_MIN  = -23'sd2097152;

    // edge table and distance store
    t_edge                    mem_edge [MAX_EDGES];
    logic signed [DIST_W-1:0] mem_dist [MAX_VERTICES];

    t_edge                    r_edge;
    logic signed [DIST_W-1:0] r_du, r_dv;
    logic [JW-1:0]            r_j, n_j;
    logic [VCW-1:0]           r_p, n_p;
    logic [MAX_VERTICES-1:0]  r_reached, n_reached;
    logic                     r_found, n_found;

    logic                     r_out_valid, n_out_valid;
    t_kind                    r_out_kind, n_out_kind;
    logic [IDX_OUT_W-1:0]     r_out_index, n_out_index;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic                     r_out_reach, n_out_reach;
    logic                     r_out_cyc, n_out_cyc;
    logic                     r_out_last, n_out_last;

    logic [VCW-1:0]           v_cnt;
    logic [ECW-1:0]           e_cnt;
    logic                     slot_ok, src_ok, u_ok, v_ok;
    logic [VIDX_W-1:0]        src_idx, u_idx, v_idx, j_vidx, rd_a;
    logic                     reach_u, reach_v, reach_e, reach_j, relax;
    logic signed [VAL_W-1:0]  cand, dv_ext;
    logic signed [VAL_W:0]    rw;
    logic signed [DIST_W-1:0] cand_sat;
    logic signed [VAL_W-1:0]  rw_sat;
    logic                     dist_we;
    logic [VIDX_W-1:0]        dist_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic                     out_load;

    // clip the configured counts to the store sizes
    assign v_cnt = (CMP_W'(i_vertex_count) < CMP_W'(MAX_VERTICES))
                 ? VCW'(i_vertex_count) : VCW'(MAX_VERTICES);
    assign e_cnt = (CMP_W'(i_edge_count) < CMP_W'(MAX_EDGES))
                 ? ECW'(i_edge_count) : ECW'(MAX_EDGES);

    assign slot_ok = CMP_W'(i_load_index) < CMP_W'(MAX_EDGES);
    assign src_ok  = CMP_W'(i_source_vertex) < CMP_W'(v_cnt);
    assign u_ok    = CMP_W'(r_edge.src) < CMP_W'(v_cnt);
    assign v_ok    = CMP_W'(r_edge.dest) < CMP_W'(v_cnt);
    assign src_idx = VIDX_W'(i_source_vertex);
    assign u_idx   = VIDX_W'(r_edge.src);
    assign v_idx   = VIDX_W'(r_edge.dest);
    assign j_vidx  = VIDX_W'(r_j);
    assign rd_a    = i_ctl.vsel ? j_vidx : u_idx;

    assign reach_u = u_ok && r_reached[u_idx];
    assign reach_v = v_ok && r_reached[v_idx];
    assign reach_e = reach_u && reach_v;
    assign reach_j = r_reached[j_vidx];

    assign dv_ext = {r_dv[DIST_W-1], r_dv};
    assign cand   = {r_du[DIST_W-1], r_du}
                  + {{(VAL_W-WEIGHT_BITS){r_edge.weight[WEIGHT_BITS-1]}}, r_edge.weight};
    assign relax  = reach_u && v_ok && (!r_reached[v_idx] || dv_ext > cand);

    always_comb begin
        if (cand > DIST_MAX) begin
            cand_sat = DIST_MAX[DIST_W-1:0];
        end else if (cand < DIST_MIN) begin
            cand_sat = DIST_MIN[DIST_W-1:0];
        end else begin
            cand_sat = cand[DIST_W-1:0];
        end
    end

    assign rw = {{(VAL_W+1-WEIGHT_BITS){r_edge.weight[WEIGHT_BITS-1]}}, r_edge.weight}
              + {{2{r_du[DIST_W-1]}}, r_du} - {{2{r_dv[DIST_W-1]}}, r_dv};

    always_comb begin
        if (rw > VAL_MAX) begin
            rw_sat = VAL_MAX[VAL_W-1:0];
        end else if (rw < VAL_MIN) begin
            rw_sat = VAL_MIN[VAL_W-1:0];
        end else begin
            rw_sat = rw[VAL_W-1:0];
        end
    end

    // distance write: zero at the source on init, relaxed value on a relax step
    assign dist_we    = i_exec && (((i_ctl.op == OP_INIT) && src_ok)
                                || ((i_ctl.op == OP_RELAX) && relax));
    assign dist_waddr = (i_ctl.op == OP_INIT) ? src_idx : v_idx;
    assign dist_wdata = (i_ctl.op == OP_INIT) ? '0 : cand_sat;

    always_ff @(posedge i_clk) begin
        if (i_load && slot_ok) begin
            mem_edge[EIDX_W'(i_load_index)] <= i_load_edge;
        end
        r_edge <= mem_edge[EIDX_W'(r_j)];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            mem_dist[dist_waddr] <= dist_wdata;
        end
        r_du <= mem_dist[rd_a];
        r_dv <= mem_dist[v_idx];
    end

    always_comb begin
        n_j       = r_j;
        n_p       = r_p;
        n_reached = r_reached;
        n_found   = r_found;
        if (i_exec) begin
            case (i_ctl.op)
                OP_INIT: begin
                    n_j       = '0;
                    n_p       = VCW'(1);
                    n_reached = '0;
                    n_found   = 1'b0;
                    if (src_ok) begin
                        n_reached[src_idx] = 1'b1;
                    end
                end
                OP_RELAX: begin
                    n_j = r_j + JW'(1);
                    if (relax) begin
                        n_reached[v_idx] = 1'b1;
                    end
                end
                OP_NEXT_PASS: begin
                    n_j = '0;
                    n_p = r_p + VCW'(1);
                end
                OP_CHECK: begin
                    n_j = r_j + JW'(1);
                    if (relax) begin
                        n_found = 1'b1;
                    end
                end
                OP_CLR_J: begin
                    n_j = '0;
                end
                OP_EMIT_VTX, OP_EMIT_EDGE: begin
                    n_j = r_j + JW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign out_load = i_exec && (i_ctl.op inside {OP_EMIT_VTX, OP_EMIT_EDGE, OP_EMIT_STAT});

    always_comb begin
        n_out_kind  = r_out_kind;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_reach = r_out_reach;
        n_out_cyc   = r_out_cyc;
        n_out_last  = r_out_last;
        if (out_load) begin
            case (i_ctl.op)
                OP_EMIT_VTX: begin
                    n_out_kind  = KIND_POTENTIAL;
                    n_out_index = IDX_OUT_W'(r_j);
                    n_out_value = reach_j ? {r_du[DIST_W-1], r_du} : '0;
                    n_out_reach = reach_j;
                    n_out_cyc   = 1'b0;
                    n_out_last  = 1'b0;
                end
                OP_EMIT_EDGE: begin
                    n_out_kind  = KIND_EDGE;
                    n_out_index = IDX_OUT_W'(r_j);
                    n_out_value = reach_e ? rw_sat : '0;
                    n_out_reach = reach_e;
                    n_out_cyc   = 1'b0;
                    n_out_last  = 1'b0;
                end
                default: begin
                    n_out_kind  = KIND_STATUS;
                    n_out_index = '0;
                    n_out_value = '0;
                    n_out_reach = 1'b0;
                    n_out_cyc   = r_found;
                    n_out_last  = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j         <= '0;
            r_p         <= '0;
            r_reached   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_j         <= n_j;
            r_p         <= n_p;
            r_reached   <= n_reached;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_reach <= n_out_reach;
        r_out_cyc   <= n_out_cyc;
        r_out_last  <= n_out_last;
    end

    assign o_flags.no_pass    = (v_cnt < VCW'(2)) || (e_cnt == '0);
    assign o_flags.no_edge    = (e_cnt == '0);
    assign o_flags.more_edges = (JW1'(r_j) + JW1'(1)) < JW1'(e_cnt);
    assign o_flags.more_pass  = (JW1'(r_p) + JW1'(1)) < JW1'(v_cnt);
    assign o_flags.no_vertex  = (v_cnt == '0);
    assign o_flags.more_vtx   = (JW1'(r_j) + JW1'(1)) < JW1'(v_cnt);
    assign o_flags.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_item_index     = r_out_index;
    assign o_value          = r_out_value;
    assign o_reachable      = r_out_reach;
    assign o_negative_cycle = r_out_cyc;
    assign o_last           = r_out_last;

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_kind == KIND_STATUS) == r_out_last))
        else $error("last flag not on the status word alone");

    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_reach |-> r_out_value == '0)
        else $error("unreachable word carries a value");

    a_init_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_exec && (i_ctl.op == OP_INIT)) |-> $onehot0(r_reached))
        else $error("more than the source reached after init");

endmodule

// ----- hw/rtl/bellman_ford_reweight.sv -----
`timescale 1ns / 1ps

// channel   direction  content
// s_axis    in         tuser: opcode; tdata: edge_index, edge_src, edge_dest, edge_weight
// m_axis    out        tuser: kind; tdata: item_index, value, reachable, negative_cycle
// apb       in/out     vertex_count @0x0, edge_count @0x4, source_vertex @0x8
//
// Each edge visit in a run costs three steps, set by the registered reads of the edge
// memory and then of the distance memory.
// Reset is synchronous and active low; the edge table is not cleared by it.
// s_axis_tready is low while a run is in progress; a stalled m_axis holds the
// sequencer at its emitting step.

module bellman_ford_reweight #(
    parameter int MAX_VERTICES = bfr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfr_pkg::MAX_EDGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [4:0] edge_index, [8:5] edge_src, [12:9] edge_dest,
                                        // [28:13] edge_weight
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] item_index, [26:5] value, [27] reachable,
                                        // [28] negative_cycle
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfr_pkg::*;

    logic [VCNT_W-1:0]       r_vertex_count;
    logic [ECNT_W-1:0]       r_edge_count;
    logic [VTX_W-1:0]        r_source_vertex;
    logic                    cfg_wr;
    logic                    in_acc;
    logic                    load;
    logic                    start;
    t_edge                   load_edge;
    t_ctl                    ctl;
    t_flags                  flags;
    logic                    exec;
    logic                    busy;
    t_kind                   out_kind;
    logic [IDX_OUT_W-1:0]    out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_reach;
    logic                    out_cyc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= VERTEX_COUNT_RESET;
            r_edge_count    <= '0;
            r_source_vertex <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_VERTEX_COUNT:  r_vertex_count  <= pwdata[VCNT_W-1:0];
                REG_EDGE_COUNT:    r_edge_count    <= pwdata[ECNT_W-1:0];
                REG_SOURCE_VERTEX: r_source_vertex <= pwdata[VTX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_VERTEX_COUNT:  prdata = 32'(r_vertex_count);
            REG_EDGE_COUNT:    prdata = 32'(r_edge_count);
            REG_SOURCE_VERTEX: prdata = 32'(r_source_vertex);
            default:           prdata = '0;
        endcase
    end

    // take words only while the sequencer is idle
    assign s_axis_tready = !busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load          = in_acc && (s_axis_tuser[0] == OPC_LOAD);
    assign start         = in_acc && (s_axis_tuser[0] == OPC_RUN);

    assign load_edge.src    = s_axis_tdata[8:5];
    assign load_edge.dest   = s_axis_tdata[12:9];
    assign load_edge.weight = s_axis_tdata[28:13];

    bfr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_exec  (exec),
        .o_busy  (busy)
    );

    bfr_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_load_index     (s_axis_tdata[4:0]),
        .i_load_edge      (load_edge),
        .i_vertex_count   (r_vertex_count),
        .i_edge_count     (r_edge_count),
        .i_source_vertex  (r_source_vertex),
        .i_ctl            (ctl),
        .i_exec           (exec),
        .i_out_ready      (m_axis_tready),
        .o_flags          (flags),
        .o_out_valid      (m_axis_tvalid),
        .o_kind           (out_kind),
        .o_item_index     (out_index),
        .o_value          (out_value),
        .o_reachable      (out_reach),
        .o_negative_cycle (out_cyc),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_cyc, out_reach, out_value, out_index};
    assign m_axis_tuser = out_kind;

endmodule
